@@ design/ptrr_pkg.sv @@
// Package with constants, types and the acceleration table of the particle trail block.
`default_nettype none

package ptrr_pkg;

	localparam int TRAIL_DEPTH_DEF = 2048;
	localparam int TRAIL_CAP       = 2000;
	localparam int ANGLE_STEPS     = 72;
	localparam int QUARTER         = ANGLE_STEPS / 4;
	localparam int Z_OFFSET        = ANGLE_STEPS * 3 / 4;

	localparam int NUM_REGS    = 8;
	localparam int REG_IDX_W   = $clog2(NUM_REGS);
	localparam int CFG_INDEX_W = REG_IDX_W + 1;

	localparam logic [REG_IDX_W-1:0] REG_START_X     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_Y     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_START_Z     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_START_VEL_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_START_VEL_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_START_VEL_Z = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LIFE_SPAN   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_START_AGE   = 3'd7;

	localparam logic [31:0] LIFE_SPAN_RST = 32'd327680;

	typedef logic signed [19:0] acc_t;

	localparam acc_t QCOS [QUARTER+1] = '{
		20'sd327680, 20'sd326433, 20'sd322702, 20'sd316515, 20'sd307918,
		20'sd296979, 20'sd283779, 20'sd268420, 20'sd251017, 20'sd231705,
		20'sd210629, 20'sd187950, 20'sd163840, 20'sd138484, 20'sd112073,
		20'sd84810,  20'sd56901,  20'sd28559,  20'sd0
	};

	// Five times the cosine of k steps of five degrees, k below twice the step count.
	function automatic acc_t cos_step(input logic [6:0] k);
		logic [6:0] m;
		logic [6:0] r;
		acc_t       v;
		m = (k >= 7'(ANGLE_STEPS)) ? k - 7'(ANGLE_STEPS) : k;
		if (m < 7'(QUARTER)) begin
			r = m;
			v = QCOS[r[4:0]];
		end else if (m < 7'(2 * QUARTER)) begin
			r = 7'(2 * QUARTER) - m;
			v = -QCOS[r[4:0]];
		end else if (m < 7'(3 * QUARTER)) begin
			r = m - 7'(2 * QUARTER);
			v = -QCOS[r[4:0]];
		end else begin
			r = 7'(4 * QUARTER) - m;
			v = QCOS[r[4:0]];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

@@ design/particle_trail_record_replay_top.sv @@
// Top level of the particle trail block: records a trail into memory, then replays it.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | input     | in_valid / in_ready  | dt, restart
//  out      | output    | out_valid / out_ready| pos_x, pos_y, pos_z, replaying
//  cfg      | input     | cfg_wen              | cfg_index, cfg_data
//
// A recording word goes from accept to result through a decision state, the
// multiply steps of the shared multiplier slice (one vector component per cycle,
// overlapped with the add of the previous one) and a trail memory write.
// A replay word issues the registered trail memory read in the decision state and loads it.
// A new word is taken while the previous result still waits in the output register.
// Reset is asynchronous and needs no clearing pass; the trail memory is only read
// below the fill count.
`default_nettype none

module particle_trail_record_replay_top
	import ptrr_pkg::*;
#(
	parameter int TRAIL_DEPTH = TRAIL_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [15:0]             dt,
	input  wire logic                    restart,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [31:0]           pos_x,
	output logic signed [31:0]           pos_y,
	output logic signed [31:0]           pos_z,
	output logic                         replaying,
	input  wire logic                    cfg_wen,
	input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [31:0]             cfg_data
);

	localparam int AW    = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
	localparam int CW    = $clog2(TRAIL_DEPTH + 1);
	localparam int LIMIT = (TRAIL_DEPTH < TRAIL_CAP) ? TRAIL_DEPTH : TRAIL_CAP;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_MAC    = 3'd2;
	localparam logic [2:0] S_WR     = 3'd3;
	localparam logic [2:0] S_LOAD   = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]         state_q;
	logic [31:0]        cfg_q [NUM_REGS];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic [6:0]         angle_q;
	logic [31:0]        age_q;
	logic [31:0]        life_q;
	logic               replay_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      ridx_q;

	logic [15:0]        dt_q;
	logic [31:0]        dt2_q;
	acc_t               acc_q [3];
	logic [1:0]         step_q;
	logic signed [31:0] dpv_q;
	logic signed [31:0] dpa_q;
	logic signed [31:0] dva_q;

	logic [95:0]        trail_mem [TRAIL_DEPTH];
	logic [95:0]        rd_q;

	logic               out_valid_q;
	logic signed [31:0] out_pos_q [3];
	logic               out_rep_q;

	logic               sw;
	logic               rep;
	logic               has_entry;
	logic [31:0]        age_base;
	logic [32:0]        age_sum;
	logic [6:0]         angle_n;
	logic [CW-1:0]      ridx_inc;
	logic               mem_we;
	logic               mem_re;
	logic               out_free;
	logic [1:0]         add_idx;
	logic signed [31:0] vel_sel;
	acc_t               acc_sel;
	logic signed [48:0] pv;
	logic signed [52:0] pa2;
	logic signed [36:0] pa1;
	logic signed [48:0] pv_sh;
	logic signed [52:0] pa2_sh;
	logic signed [36:0] pa1_sh;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign pos_x     = out_pos_q[0];
	assign pos_y     = out_pos_q[1];
	assign pos_z     = out_pos_q[2];
	assign replaying = out_rep_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		sw        = !replay_q && ((cnt_q >= CW'(LIMIT)) || (age_q > life_q));
		rep       = replay_q || sw;
		has_entry = (cnt_q != '0) && (ridx_q < cnt_q);
		age_base  = (rep && (ridx_q == '0)) ? 32'd0 : age_q;
		age_sum   = {1'b0, age_base} + {17'd0, dt_q};
		angle_n   = (angle_q == 7'(ANGLE_STEPS - 1)) ? 7'd0 : angle_q + 7'd1;
		ridx_inc  = ridx_q + CW'(1);
		mem_we    = (state_q == S_WR);
		mem_re    = (state_q == S_DECIDE) && rep && has_entry;
		add_idx   = step_q - 2'd1;
	end

	always_comb begin
		case (step_q)
			2'd0: begin
				vel_sel = vel_q[0];
				acc_sel = acc_q[0];
			end
			2'd1: begin
				vel_sel = vel_q[1];
				acc_sel = acc_q[1];
			end
			2'd2: begin
				vel_sel = vel_q[2];
				acc_sel = acc_q[2];
			end
			default: begin
				vel_sel = '0;
				acc_sel = '0;
			end
		endcase
	end

	assign pv     = vel_sel * $signed({1'b0, dt_q});
	assign pa2    = acc_sel * $signed({1'b0, dt2_q});
	assign pa1    = acc_sel * $signed({1'b0, dt_q});
	assign pv_sh  = pv >>> 16;
	assign pa2_sh = pa2 >>> 33;
	assign pa1_sh = pa1 >>> 16;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			trail_mem[cnt_q[AW-1:0]] <= {pos_q[2], pos_q[1], pos_q[0]};
		end
		if (mem_re) begin
			rd_q <= trail_mem[ridx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
			cfg_q[REG_LIFE_SPAN] <= LIFE_SPAN_RST;
		end else if (cfg_wen && (cfg_index < CFG_INDEX_W'(NUM_REGS))) begin
			cfg_q[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dt_q <= dt;
			end
			S_DECIDE: begin
				dt2_q     <= 32'(dt_q * dt_q);
				acc_q[0]  <= cos_step(angle_n);
				acc_q[1]  <= '0;
				acc_q[2]  <= cos_step(angle_n + 7'(Z_OFFSET));
			end
			S_MAC: begin
				dpv_q <= pv_sh[31:0];
				dpa_q <= pa2_sh[31:0];
				dva_q <= pa1_sh[31:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
			angle_q  <= '0;
			age_q    <= '0;
			life_q   <= LIFE_SPAN_RST;
			replay_q <= 1'b0;
			cnt_q    <= '0;
			ridx_q   <= '0;
			step_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							pos_q[0] <= cfg_q[REG_START_X];
							pos_q[1] <= cfg_q[REG_START_Y];
							pos_q[2] <= cfg_q[REG_START_Z];
							vel_q[0] <= cfg_q[REG_START_VEL_X];
							vel_q[1] <= cfg_q[REG_START_VEL_Y];
							vel_q[2] <= cfg_q[REG_START_VEL_Z];
							angle_q  <= '0;
							age_q    <= cfg_q[REG_START_AGE];
							life_q   <= cfg_q[REG_LIFE_SPAN];
							replay_q <= 1'b0;
							cnt_q    <= '0;
							ridx_q   <= '0;
						end
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (sw) begin
						life_q   <= age_q;
						replay_q <= 1'b1;
					end
					age_q <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
					if (!rep) begin
						angle_q <= angle_n;
						step_q  <= '0;
						state_q <= S_MAC;
					end else if (has_entry) begin
						ridx_q  <= (ridx_inc == cnt_q) ? '0 : ridx_inc;
						state_q <= S_LOAD;
					end else begin
						ridx_q  <= '0;
						state_q <= S_FIN;
					end
				end
				S_MAC: begin
					for (int i = 0; i < 3; i++) begin
						if ((step_q != 2'd0) && (add_idx == 2'(i))) begin
							pos_q[i] <= pos_q[i] + dpv_q + dpa_q;
							vel_q[i] <= vel_q[i] + dva_q;
						end
					end
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_FIN;
				end
				S_LOAD: begin
					pos_q[0] <= rd_q[31:0];
					pos_q[1] <= rd_q[63:32];
					pos_q[2] <= rd_q[95:64];
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			for (int i = 0; i < 3; i++) begin
				out_pos_q[i] <= pos_q[i];
			end
			out_rep_q <= replay_q;
		end
	end

endmodule

`default_nettype wire

@@ design/ptrr_checker.sv @@
// Port-level checker for the particle trail block, with its bind statement.
`default_nettype none

module ptrr_checker
	import ptrr_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic [15:0]            dt,
	input wire logic                   restart,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic signed [31:0]     pos_x,
	input wire logic signed [31:0]     pos_y,
	input wire logic signed [31:0]     pos_z,
	input wire logic                   replaying,
	input wire logic                   cfg_wen,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [31:0]            cfg_data
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({pos_x, pos_y, pos_z, replaying}))
		else $error("Output word changed or dropped while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("Input taken again in the cycle after a word was accepted.");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("Output word shown without an accepted input word.");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("More than two words in flight.");

	logic unused_ok;
	assign unused_ok = &{1'b0, dt, restart, cfg_wen, cfg_index, cfg_data};

endmodule

bind particle_trail_record_replay_top ptrr_checker u_ptrr_checker (.*);

`default_nettype wire
